// File: rtl/core/tcsdft_pkg.sv
// ---------------------------------------------------------------------------
// tcsdft_pkg: shared types and constants
// CORDIC angle table, gain, and the control struct for the shared CORDIC unit.
// ---------------------------------------------------------------------------
package tcsdft_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned StepBits    = 5;
  localparam int unsigned CordicW     = 48;
  localparam logic [31:0] CordicGain  = 32'd652032875;
  localparam logic [31:0] OscStepRst  = 32'd629145600;

  typedef enum logic [1:0] {
    CMODE_ROTATE = 2'b01,
    CMODE_VECTOR = 2'b10
  } cmode_e;

  typedef struct packed {
    logic   start;
    cmode_e mode;
  } cordic_ctrl_t;

  function automatic logic [31:0] atan_lut(input logic [StepBits-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/tcsdft_if.sv
// ---------------------------------------------------------------------------
// tcsdft_in_if / tcsdft_out_if: valid/ready channels
// Input carries three samples, output carries phases, deltas and heading.
// ---------------------------------------------------------------------------
interface tcsdft_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_ref;
  logic [15:0] sample_y;
  logic [15:0] sample_x;
  modport source (output valid, sample_ref, sample_y, sample_x, input ready);
  modport sink   (input valid, sample_ref, sample_y, sample_x, output ready);
endinterface

interface tcsdft_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] phase_ref;
  logic signed [15:0] phase_y;
  logic signed [15:0] phase_x;
  logic signed [15:0] delta_y;
  logic signed [15:0] delta_x;
  logic signed [15:0] heading;
  modport source (output valid, phase_ref, phase_y, phase_x, delta_y, delta_x, heading,
                  input ready);
  modport sink   (input valid, phase_ref, phase_y, phase_x, delta_y, delta_x, heading,
                  output ready);
endinterface

// File: rtl/core/tcsdft_cordic.sv
// ---------------------------------------------------------------------------
// tcsdft_cordic: shared iterative CORDIC
// One micro-rotation per cycle, rotation mode for sin/cos, vectoring for atan2.
// ---------------------------------------------------------------------------
module tcsdft_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tcsdft_pkg::cordic_ctrl_t          ctrl_i,
  input  logic signed [tcsdft_pkg::CordicW-1:0] x_i,
  input  logic signed [tcsdft_pkg::CordicW-1:0] y_i,
  input  logic [31:0]                       z_i,
  output logic signed [tcsdft_pkg::CordicW-1:0] x_o,
  output logic signed [tcsdft_pkg::CordicW-1:0] y_o,
  output logic [31:0]                       z_o,
  output logic                              done_o
);

  localparam int unsigned W = tcsdft_pkg::CordicW;

  logic signed [W-1:0] x_q, x_d, y_q, y_d;
  logic [31:0]         z_q, z_d;
  logic [tcsdft_pkg::StepBits-1:0] i_q, i_d;
  logic                busy_q, busy_d, done_q, done_d;
  tcsdft_pkg::cmode_e  mode_q, mode_d;
  logic                dir;
  logic signed [W-1:0] xs, ys;
  logic [31:0]         at;

  always_comb begin
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    at = tcsdft_pkg::atan_lut(i_q);
    // rotate: turn toward the remaining angle; vector: drive y to zero
    if (mode_q == tcsdft_pkg::CMODE_ROTATE) dir = ~z_q[31];
    else                                    dir = (y_q > 0);
    x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q;
    busy_d = busy_q; mode_d = mode_q; done_d = 1'b0;
    if (ctrl_i.start) begin
      x_d = x_i; y_d = y_i; z_d = z_i; i_d = '0;
      busy_d = 1'b1; mode_d = ctrl_i.mode;
    end else if (busy_q) begin
      if (mode_q == tcsdft_pkg::CMODE_ROTATE) begin
        if (dir) begin x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - at; end
        else     begin x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + at; end
      end else begin
        if (dir) begin x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + at; end
        else     begin x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - at; end
      end
      i_d = i_q + 1'b1;
      if (i_q == tcsdft_pkg::StepBits'(tcsdft_pkg::CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
      mode_q <= tcsdft_pkg::CMODE_ROTATE;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      i_q    <= i_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign done_o = done_q;

endmodule

// File: rtl/core/three_channel_sliding_dft_phase_core.sv
// ---------------------------------------------------------------------------
// three_channel_sliding_dft_phase_core: sliding single-bin DFT, phase, heading
// Three-hydrophone bin phase, phase differences and heading angle.
// ---------------------------------------------------------------------------
// Usage: in_if carries one sample per hydrophone per item; out_if returns
// the three bin phases, two wrapped differences and the heading, all binary
// angles (-32768 is -pi). osc_step_we_i/osc_step_i set the oscillator step;
// the user must write it only while idle, the block itself does not enforce
// this. One shared CORDIC does all the work: one sin/cos rotation, then per
// channel a product read and write, a seed step, up to 39 one-bit
// normalization shifts, a start and a vectoring, and the same save the
// product access for the heading. A zero vector or one on an axis skips its
// normalization and vectoring. in_if is ready only while the sequencer is
// idle and the output register is free, so the next item is taken no
// earlier than the cycle after the result is taken. The result register
// holds until taken; a stalled receiver holds the block.
// Reset clears the oscillator phase, window pointer, sums, and starts a
// clearing pass over all 3*WINDOW product memory entries (192 by default)
// with no input accepted.
// ---------------------------------------------------------------------------
module three_channel_sliding_dft_phase_core #(
  parameter int unsigned WINDOW = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               osc_step_we_i,
  input  logic [31:0]        osc_step_i,
  tcsdft_in_if.sink          in_if,
  tcsdft_out_if.source       out_if
);

  localparam int unsigned HW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned DEPTH = 3 * WINDOW;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned SUMW = 32 + HW;
  localparam int unsigned W = tcsdft_pkg::CordicW;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_TRIG  = 9'b000000100,
    S_RDPR  = 9'b000001000,
    S_UPD   = 9'b000010000,
    S_NORM  = 9'b000100000,
    S_VEC   = 9'b001000000,
    S_HEAD  = 9'b010000000,
    S_HVEC  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] osc_step_q, osc_phase_q;
  logic [HW-1:0] head_q;
  logic [AW-1:0] clr_q;
  logic [1:0]  ch_q;
  logic [15:0] smp_q [3];
  logic signed [SUMW-1:0] csum_q [3];
  logic signed [SUMW-1:0] ssum_q [3];
  logic signed [15:0] c_q, s_q;
  logic [15:0] ph_q [3];
  logic signed [W-1:0] nx_q, ny_q;
  logic        nrm_neg_q, seed_q;
  logic        trivial_q;
  logic [31:0] triv_z_q;

  // product memory: {cos, sin} products, 32 bits each
  logic [63:0] mem [DEPTH];
  logic [63:0] rd_q;
  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic [63:0] mem_wd;

  logic        out_valid_q;
  logic [15:0] o_q [6];

  tcsdft_pkg::cordic_ctrl_t cctl;
  logic signed [W-1:0] cx_i, cy_i, cx_o, cy_o;
  logic [31:0] cz_i, cz_o;
  logic        cdone;

  tcsdft_cordic u_cordic (
    .clk_i, .rst_ni, .ctrl_i(cctl), .x_i(cx_i), .y_i(cy_i), .z_i(cz_i),
    .x_o(cx_o), .y_o(cy_o), .z_o(cz_o), .done_o(cdone)
  );

  function automatic logic signed [15:0] trig_rnd(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    r = (v + W'(32'sd16384)) >>> 15;
    if (r > W'(32'sd32767)) r = W'(32'sd32767);
    if (r < -W'(32'sd32767)) r = -W'(32'sd32767);
    return r[15:0];
  endfunction

  function automatic logic [15:0] to_ang(input logic [31:0] z);
    logic [31:0] t;
    t = z + 32'h0000_8000;
    return t[31:16];
  endfunction

  // current window slot for channel
  logic [AW-1:0] slot;
  assign slot = AW'(ch_q) * AW'(WINDOW) + AW'(head_q);

  // sum update
  logic signed [31:0] cp, sp, cold, sold;
  logic signed [SUMW-1:0] cnew, snew;
  always_comb begin
    cp   = $signed({16'd0, smp_q[ch_q]}) * 32'(c_q);
    sp   = $signed({16'd0, smp_q[ch_q]}) * 32'(s_q);
    cold = rd_q[63:32];
    sold = rd_q[31:0];
    cnew = csum_q[ch_q] + SUMW'(cp) - SUMW'(cold);
    snew = ssum_q[ch_q] + SUMW'(sp) - SUMW'(sold);
  end

  // vectoring operand prep: x, y of the current atan2
  logic signed [W-1:0] vx, vy;
  logic signed [15:0] dyv, dxv;
  assign dyv = ph_q[1] - ph_q[0];
  assign dxv = ph_q[2] - ph_q[0];
  always_comb begin
    if (state_q == S_HEAD) begin
      vx = W'(dxv);
      vy = W'(dyv);
    end else begin
      vx = W'(csum_q[ch_q]);
      vy = W'(ssum_q[ch_q]);
    end
  end

  // one-bit normalization step toward [2^39, 2^40)
  logic norm_done;
  assign norm_done = !nx_q[W-1] && ((nx_q[W-1] ? -nx_q : nx_q) >= 0)
                     && (((nx_q >= (ny_q[W-1] ? -ny_q : ny_q)) ? nx_q :
                          (ny_q[W-1] ? -ny_q : ny_q)) < (W'(1) <<< 40))
                     && (((nx_q >= (ny_q[W-1] ? -ny_q : ny_q)) ? nx_q :
                          (ny_q[W-1] ? -ny_q : ny_q)) >= (W'(1) <<< 39));
  logic signed [W-1:0] nmag;
  assign nmag = (nx_q >= (ny_q[W-1] ? -ny_q : ny_q)) ? nx_q : (ny_q[W-1] ? -ny_q : ny_q);

  logic in_fire, out_fire;
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign in_if.ready = (state_q == S_IDLE) && !out_valid_q;

  // trig seed: quadrant fold
  logic signed [32:0] pa;
  logic        tneg;
  logic [31:0] tz;
  always_comb begin
    pa = $signed({osc_phase_q[31], osc_phase_q});
    tneg = 1'b0;
    tz = osc_phase_q;
    if (pa > 33'sd1073741824) begin tz = osc_phase_q - 32'h8000_0000; tneg = 1'b1; end
    else if (pa < -33'sd1073741824) begin tz = osc_phase_q + 32'h8000_0000; tneg = 1'b1; end
  end

  always_comb begin
    state_d = state_q;
    cctl.start = 1'b0;
    cctl.mode  = tcsdft_pkg::CMODE_ROTATE;
    cx_i = W'(tcsdft_pkg::CordicGain);
    cy_i = '0;
    cz_i = tz;
    mem_we = 1'b0;
    mem_addr = slot;
    mem_wd = {cp, sp};
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_q;
        mem_wd = '0;
        if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: if (in_fire) begin
        state_d = S_TRIG;
        cctl.start = 1'b1;
      end
      S_TRIG: if (cdone) state_d = S_RDPR;
      S_RDPR: state_d = S_UPD;
      S_UPD: begin
        mem_we = 1'b1;
        state_d = S_NORM;
      end
      S_NORM, S_HEAD: begin
        // hold during the seed cycle
        if (!seed_q) state_d = state_q;
        else if (trivial_q) state_d = (state_q == S_NORM) ? S_VEC : S_HVEC;
        else if (norm_done) begin
          cctl.start = 1'b1;
          cctl.mode  = tcsdft_pkg::CMODE_VECTOR;
          cx_i = nx_q;
          cy_i = ny_q;
          cz_i = nrm_neg_q ? 32'h8000_0000 : 32'h0;
          state_d = (state_q == S_NORM) ? S_VEC : S_HVEC;
        end
      end
      S_VEC: if (trivial_q || cdone) begin
        state_d = (ch_q == 2'd2) ? S_HEAD : S_RDPR;
      end
      S_HVEC: if (trivial_q || cdone) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rd_q <= mem[slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      osc_step_q  <= tcsdft_pkg::OscStepRst;
      osc_phase_q <= '0;
      head_q      <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      seed_q      <= 1'b0;
      trivial_q   <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        csum_q[k] <= '0;
        ssum_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (osc_step_we_i) osc_step_q <= osc_step_i;
      if (out_fire) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: clr_q <= clr_q + 1'b1;
        S_IDLE: if (in_fire) begin
          ch_q <= '0;
          nrm_neg_q <= tneg;
        end
        S_TRIG: if (cdone) begin
          c_q <= nrm_neg_q ? -trig_rnd(cx_o) : trig_rnd(cx_o);
          s_q <= nrm_neg_q ? -trig_rnd(cy_o) : trig_rnd(cy_o);
        end
        S_RDPR: ;
        S_UPD: begin
          csum_q[ch_q] <= cnew;
          ssum_q[ch_q] <= snew;
          seed_q <= 1'b0;
        end
        S_NORM, S_HEAD: begin
          if (!seed_q) begin
            // seed: special cases and sign fold
            seed_q <= 1'b1;
            trivial_q <= (vy == 0) || (vx == 0);
            if (vy == 0) triv_z_q <= vx[W-1] ? 32'h8000_0000 : 32'h0;
            else triv_z_q <= vy[W-1] ? 32'hC000_0000 : 32'h4000_0000;
            nrm_neg_q <= vx[W-1];
            nx_q <= vx[W-1] ? -vx : vx;
            ny_q <= vx[W-1] ? -vy : vy;
          end else if (!trivial_q && !norm_done) begin
            if (nmag >= (W'(1) <<< 40)) begin
              nx_q <= nx_q >>> 1;
              ny_q <= ny_q >>> 1;
            end else begin
              nx_q <= nx_q <<< 1;
              ny_q <= ny_q <<< 1;
            end
          end
        end
        S_VEC: if (trivial_q || cdone) begin
          ph_q[ch_q] <= to_ang(trivial_q ? triv_z_q : cz_o);
          ch_q <= ch_q + 1'b1;
          seed_q <= 1'b0;
          trivial_q <= 1'b0;
        end
        S_HVEC: if (trivial_q || cdone) begin
          o_q[0] <= ph_q[0];
          o_q[1] <= ph_q[1];
          o_q[2] <= ph_q[2];
          o_q[3] <= dyv;
          o_q[4] <= dxv;
          o_q[5] <= to_ang(trivial_q ? triv_z_q : cz_o);
          out_valid_q <= 1'b1;
          head_q <= (head_q == HW'(WINDOW - 1)) ? '0 : head_q + 1'b1;
          osc_phase_q <= osc_phase_q + osc_step_q;
          trivial_q <= 1'b0;
        end
        default: ;
      endcase
      if (state_q == S_IDLE && in_fire) begin
        smp_q[0] <= in_if.sample_ref;
        smp_q[1] <= in_if.sample_y;
        smp_q[2] <= in_if.sample_x;
      end
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.phase_ref = o_q[0];
  assign out_if.phase_y   = o_q[1];
  assign out_if.phase_x   = o_q[2];
  assign out_if.delta_y   = o_q[3];
  assign out_if.delta_x   = o_q[4];
  assign out_if.heading   = o_q[5];

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> (state_q == S_IDLE)) else $error("ready outside idle");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_if.ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> out_if.valid) else $error("result dropped");

endmodule

// File: dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench for three_channel_sliding_dft_phase_core
// Drives sample items with random gaps, stalls the result side, predicts each
// result from a bit-exact model of the oscillator, the sliding sums and the
// CORDIC angles, and compares every field. It steps the oscillator step
// through several values, the extremes among them.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Window = 64;
  localparam int Steps  = 24;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [15:0] s_ref;
    logic [15:0] s_y;
    logic [15:0] s_x;
  } samples_t;

  typedef struct packed {
    logic [15:0] p_ref;
    logic [15:0] p_y;
    logic [15:0] p_x;
    logic [15:0] d_y;
    logic [15:0] d_x;
    logic [15:0] hd;
  } angles_t;

  typedef struct {
    samples_t smp;
    bit       has_exp;
    angles_t  exp;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic osc_step_we_i = 1'b0;
  logic [31:0] osc_step_i = '0;

  tcsdft_in_if  in_if ();
  tcsdft_out_if out_if ();

  three_channel_sliding_dft_phase_core dut (
    .clk_i, .rst_ni, .osc_step_we_i, .osc_step_i,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0]        osc_step_m;
  logic [31:0]        osc_phase_m;
  longint             cos_prod[3*Window];
  longint             sin_prod[3*Window];
  longint             cos_sum[3];
  longint             sin_sum[3];
  int                 head_m;
  angles_t            pending_angles[$];

  bit failed = 1'b0;
  bit quiet  = 1'b0;
  int idle_cnt = 0;
  int stall_left = 0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_trig(longint v);
    longint r;
    r = floor_shr(v + (64'sd1 << 14), 15);
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return r;
  endfunction

  task automatic osc_trig(input logic [31:0] ph, output longint c, output longint s);
    longint a, x, y, nx;
    bit flip;
    a = longint'(signed'(ph));
    x = tcsdft_pkg::CordicGain;
    y = 0;
    flip = 1'b0;
    if (a > (64'sd1 << 30)) begin
      a -= 64'sd1 << 31; flip = 1'b1;
    end else if (a < -(64'sd1 << 30)) begin
      a += 64'sd1 << 31; flip = 1'b1;
    end
    for (int i = 0; i < Steps; i++) begin
      if (a >= 0) begin
        nx = x - floor_shr(y, i); y = y + floor_shr(x, i);
        a -= longint'(tcsdft_pkg::atan_lut(i[4:0]));
      end else begin
        nx = x + floor_shr(y, i); y = y - floor_shr(x, i);
        a += longint'(tcsdft_pkg::atan_lut(i[4:0]));
      end
      x = nx;
    end
    c = round_trig(x);
    s = round_trig(y);
    if (flip) begin
      c = -c; s = -s;
    end
  endtask

  function automatic logic [31:0] vector_angle(longint y, longint x);
    logic [31:0] z;
    longint nx, ax, ay, m;
    z = '0;
    if (y == 0) return (x >= 0) ? 32'h0 : 32'h8000_0000;
    if (x == 0) return (y > 0) ? 32'h4000_0000 : 32'hC000_0000;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    ax = x;
    ay = (y < 0) ? -y : y;
    m = (ax > ay) ? ax : ay;
    while (m >= (64'sd1 << 40)) begin
      x = floor_shr(x, 1); y = floor_shr(y, 1); m = m >> 1;
    end
    while (m < (64'sd1 << 39)) begin
      x = x * 2; y = y * 2; m = m << 1;
    end
    for (int i = 0; i < Steps; i++) begin
      if (y > 0) begin
        nx = x + floor_shr(y, i); y = y - floor_shr(x, i);
        z += tcsdft_pkg::atan_lut(i[4:0]);
      end else begin
        nx = x - floor_shr(y, i); y = y + floor_shr(x, i);
        z -= tcsdft_pkg::atan_lut(i[4:0]);
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic logic [15:0] angle16(logic [31:0] z);
    logic [31:0] t;
    t = z + 32'h8000;
    return t[31:16];
  endfunction

  task automatic bin_predict(input samples_t smp, output angles_t res);
    longint c, s, v, cp, sp;
    logic [15:0] ph[3];
    logic [15:0] dy, dx;
    int idx;
    osc_trig(osc_phase_m, c, s);
    for (int ch = 0; ch < 3; ch++) begin
      v = (ch == 0) ? smp.s_ref : (ch == 1) ? smp.s_y : smp.s_x;
      idx = ch * Window + head_m;
      cp = v * c;
      sp = v * s;
      cos_sum[ch] += cp - cos_prod[idx];
      sin_sum[ch] += sp - sin_prod[idx];
      cos_prod[idx] = cp;
      sin_prod[idx] = sp;
      ph[ch] = angle16(vector_angle(sin_sum[ch], cos_sum[ch]));
    end
    head_m = (head_m + 1 >= Window) ? 0 : head_m + 1;
    osc_phase_m += osc_step_m;
    dy = ph[1] - ph[0];
    dx = ph[2] - ph[0];
    res.p_ref = ph[0];
    res.p_y = ph[1];
    res.p_x = ph[2];
    res.d_y = dy;
    res.d_x = dx;
    res.hd = angle16(vector_angle(longint'(signed'(dy)), longint'(signed'(dx))));
  endtask

  task automatic send_samples(input samples_t smp);
    angles_t e;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    {in_if.sample_ref, in_if.sample_y, in_if.sample_x} <= smp;
    do @(posedge clk_i); while (!in_if.ready);
    bin_predict(smp, e);
    pending_angles.push_back(e);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    // the block is idle once the last result is out; margin for safety
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_step(input logic [31:0] v);
    osc_step_we_i <= 1'b1;
    osc_step_i <= v;
    @(posedge clk_i);
    osc_step_we_i <= 1'b0;
    osc_step_m = v;
  endtask

  // receive side: random stall bursts unless quiet, compare against the oldest prediction
  always @(posedge clk_i) begin
    angles_t got, want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.phase_ref, out_if.phase_y, out_if.phase_x,
               out_if.delta_y, out_if.delta_x, out_if.heading};
        if (pending_angles.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          failed = 1'b1;
        end else begin
          want = pending_angles.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            failed = 1'b1;
          end
        end
      end
      if (quiet) out_if.ready <= 1'b1;
      else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (out_if.ready && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= 1'b0;
    end
  end

  // watchdog: cycles without any accepted item or taken result
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  dir_row_t dir_rows[$];
  samples_t rs;
  logic [31:0] step_set[6];

  initial begin
    angles_t zero_res;
    in_if.valid = 1'b0;
    in_if.sample_ref = '0;
    in_if.sample_y = '0;
    in_if.sample_x = '0;
    osc_step_m = tcsdft_pkg::OscStepRst;
    osc_phase_m = '0;
    foreach (cos_prod[i]) begin
      cos_prod[i] = 0; sin_prod[i] = 0;
    end
    for (int i = 0; i < 3; i++) begin
      cos_sum[i] = 0; sin_sum[i] = 0;
    end
    head_m = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero samples give the zero vector everywhere
    zero_res = '0;
    dir_rows.push_back('{'0, 1'b1, zero_res});
    dir_rows.push_back('{{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, zero_res});
    dir_rows.push_back('{{16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0, zero_res});
    dir_rows.push_back('{{16'h0000, 16'hFFFF, 16'h0000}, 1'b0, zero_res});
    dir_rows.push_back('{{16'h8000, 16'h0001, 16'h7FFF}, 1'b0, zero_res});
    dir_rows.push_back('{{16'h5555, 16'hAAAA, 16'h0001}, 1'b0, zero_res});
    foreach (dir_rows[r]) begin
      send_samples(dir_rows[r].smp);
      if (dir_rows[r].has_exp) pending_angles[pending_angles.size()-1] = dir_rows[r].exp;
    end
    drain_results();

    // step zero holds the oscillator phase where the last test left it
    write_step(32'h0000_0000);
    for (int i = 0; i < 6; i++) send_samples({16'hFFFF, 16'(i * 9000), 16'h0});
    drain_results();
    // step of half a turn flips the oscillator sign on every item
    write_step(32'h8000_0000);
    for (int i = 0; i < 6; i++) send_samples({16'(i[0] ? 16'h0 : 16'hFFFF), 16'h1, 16'hFFFF});
    drain_results();
    write_step(32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send_samples({16'h7FFF, 16'h0, 16'h8000});
    drain_results();

    step_set = '{32'h4000_0000, tcsdft_pkg::OscStepRst, 32'h0000_0001, 32'hFFFF_FFFF,
                 32'h1234_5678, 32'h0000_0000};
    for (int ph = 0; ph < 6; ph++) begin
      write_step((ph == 4) ? $urandom() : step_set[ph]);
      if (ph == 5) quiet = 1'b1;
      for (int n = 0; n < 150; n++) begin
        case ($urandom_range(0, 3))
          0: rs = {16'($urandom()), 16'($urandom()), 16'($urandom())};
          1: rs = {16'($urandom_range(0, 3)), 16'($urandom()), 16'hFFFF - 16'($urandom_range(0, 3))};
          2: rs = {16'h8000 + 16'($urandom_range(0, 255)), 16'h8000, 16'($urandom())};
          default: rs = {16'h0, 16'h0, 16'($urandom_range(0, 1)) * 16'hFFFF};
        endcase
        send_samples(rs);
      end
      in_if.valid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clk_i);
      repeat (20) @(posedge clk_i);
    end

    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
